// ===== hdl/gbfe_pkg.sv =====
// Package for the GB18030 four-byte range encoder.
// Holds the range table, index widths and the reciprocal constants used by
// the divide stages. No dependencies.
package gbfe_pkg;

   // Number of four-byte ranges and the width of the linear index.
   localparam int NUM_RANGES = 13;
   localparam int INDEX_W    = 21;
   localparam int CP_W       = 32;

   // Index arithmetic constants.
   localparam logic [31:0] INDEX_BASE = 32'd1687218;
   localparam logic [7:0]  LEAD_BASE  = 8'h81;
   localparam logic [7:0]  DIGIT_BASE = 8'h30;

   // Widths of the quotients and remainders along the pipeline.
   localparam int QUOT1_W = 17;  // index / 10
   localparam int QUOT2_W = 10;  // index / 1260
   localparam int QUOT3_W = 7;   // index / 12600
   localparam int DIGIT_W = 4;   // remainder of a divide by ten
   localparam int REM126_W = 7;  // remainder of a divide by 126

   // Reciprocal constants; each is exact over the range of its operand.
   localparam int          DIV10A_SHIFT = 24;
   localparam logic [41:0] DIV10A_RECIP = 42'd1677722;
   localparam int          DIV63_SHIFT  = 22;
   localparam logic [32:0] DIV63_RECIP  = 33'd66577;
   localparam int          DIV10B_SHIFT = 14;
   localparam logic [20:0] DIV10B_RECIP = 21'd1639;

   // Range bounds, inclusive, and the offset that each range adds.
   localparam logic [31:0] RANGE_LO [NUM_RANGES] = '{
      32'h0000_0452, 32'h0000_2643, 32'h0000_361B, 32'h0000_3CE1,
      32'h0000_4160, 32'h0000_44D7, 32'h0000_478E, 32'h0000_49B8,
      32'h0000_9FA6, 32'h0000_E865, 32'h0000_FA2A, 32'h0000_FFE6,
      32'h0001_0000
   };
   localparam logic [31:0] RANGE_HI [NUM_RANGES] = '{
      32'h0000_200F, 32'h0000_2E80, 32'h0000_3917, 32'h0000_4055,
      32'h0000_4336, 32'h0000_464B, 32'h0000_4946, 32'h0000_4C76,
      32'h0000_D7FF, 32'h0000_F92B, 32'h0000_FE2F, 32'h0000_FFFF,
      32'h0010_FFFF
   };
   localparam logic [31:0] RANGE_BASE [NUM_RANGES] = '{
      32'd1688038, 32'd1696437, 32'd1700191, 32'd1701916,
      32'd1703065, 32'd1703947, 32'd1704636, 32'd1705179,
      32'd1706261, 32'd1720768, 32'd1725296, 32'd1726612,
      32'd1876218
   };

   // Result of the range lookup: hit flag and the value added to the
   // low bits of the code point (modulo the index width).
   typedef struct packed {
      logic               hit;
      logic [INDEX_W-1:0] delta;
   } gbfe_match_type;

   // Delta of one range: base minus index base minus range start.
   function automatic logic [INDEX_W-1:0] range_delta(input int k);
      logic [31:0] full;
      full = RANGE_BASE[k] - INDEX_BASE - RANGE_LO[k];
      return full[INDEX_W-1:0];
   endfunction

endpackage

// ===== hdl/gb18030_four_byte_encoder_top.sv =====
// Top level of the GB18030 four-byte range encoder.
// Five-stage pipeline; uses gbfe_pkg and gbfe_range_match.

// Accepts one code point per clock while req_stall is low and returns one
// result beat per code point. The five register stages are the range
// lookup, the index add, and three constant-divide stages (by 10, by 126
// and by 10 again), the last of which is the output register. Each stage
// holds while the one after it is full and stalled; an empty stage always
// loads, so bubbles close up and req_stall rises only when every stage is
// full and rsp_stall is high.
// Code points outside every four-byte range return mapped low and all four
// bytes zero.
module gb18030_four_byte_encoder_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [gbfe_pkg::CP_W-1:0]  req_code_point,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_mapped,
   output logic [7:0]                 rsp_first_byte,
   output logic [7:0]                 rsp_second_byte,
   output logic [7:0]                 rsp_third_byte,
   output logic [7:0]                 rsp_fourth_byte
);
   import gbfe_pkg::*;

   // Stage registers.
   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   gbfe_match_type       s1_match_ff;
   logic [INDEX_W-1:0]   s1_cp_ff;
   logic                 s2_hit_ff, s3_hit_ff, s4_hit_ff, s5_hit_ff;
   logic [INDEX_W-1:0]   s2_index_ff;
   logic [QUOT1_W-1:0]   s3_quot_ff;
   logic [DIGIT_W-1:0]   s3_digit_ff, s4_digit_ff;
   logic [QUOT2_W-1:0]   s4_quot_ff;
   logic [REM126_W-1:0]  s4_rem_ff;
   logic [7:0]           s5_first_ff, s5_second_ff, s5_third_ff, s5_fourth_ff;

   // Next values.
   gbfe_match_type       match_in;
   logic [INDEX_W-1:0]   s2_index_in;
   logic [41:0]          div10a_prod;
   logic [QUOT1_W-1:0]   s3_quot_in;
   logic [INDEX_W-1:0]   s3_rem_full;
   logic [32:0]          div63_prod;
   logic [QUOT2_W-1:0]   s4_quot_in;
   logic [QUOT1_W-1:0]   s4_rem_full;
   logic [20:0]          div10b_prod;
   logic [QUOT3_W-1:0]   s5_quot_in;
   logic [QUOT2_W-1:0]   s5_rem_full;

   // Per-stage advance: a stage loads when it is empty or the next one moves.
   logic adv1, adv2, adv3, adv4, adv5;

   assign adv5 = !s5_valid_ff || !rsp_stall;
   assign adv4 = !s4_valid_ff || adv5;
   assign adv3 = !s3_valid_ff || adv4;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_stall = !adv1;

   // Stage 1: parallel range compares.
   gbfe_range_match u_match (
      .code_point (req_code_point),
      .match      (match_in)
   );

   // Stage 2: linear index from the low code point bits and the range delta.
   assign s2_index_in = s1_cp_ff + s1_match_ff.delta;

   // Stage 3: index divided by ten; the remainder is the fourth digit.
   assign div10a_prod = {{(42-INDEX_W){1'b0}}, s2_index_ff} * DIV10A_RECIP;
   assign s3_quot_in  = div10a_prod[DIV10A_SHIFT +: QUOT1_W];
   assign s3_rem_full = s2_index_ff
                      - ({{(INDEX_W-QUOT1_W){1'b0}}, s3_quot_in} * INDEX_W'(10));

   // Stage 4: divide by 126 as a halving followed by a divide by 63.
   assign div63_prod  = {{(33-QUOT1_W+1){1'b0}}, s3_quot_ff[QUOT1_W-1:1]} * DIV63_RECIP;
   assign s4_quot_in  = div63_prod[DIV63_SHIFT +: QUOT2_W];
   assign s4_rem_full = s3_quot_ff
                      - ({{(QUOT1_W-QUOT2_W){1'b0}}, s4_quot_in} * QUOT1_W'(126));

   // Stage 5: final divide by ten gives the lead byte and the second digit.
   assign div10b_prod = {{(21-QUOT2_W){1'b0}}, s4_quot_ff} * DIV10B_RECIP;
   assign s5_quot_in  = div10b_prod[DIV10B_SHIFT +: QUOT3_W];
   assign s5_rem_full = s4_quot_ff
                      - ({{(QUOT2_W-QUOT3_W){1'b0}}, s5_quot_in} * QUOT2_W'(10));

   // Valid bits travel with the data and clear on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= req_valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
         if (adv4) s4_valid_ff <= s3_valid_ff;
         if (adv5) s5_valid_ff <= s4_valid_ff;
      end
   end

   // Payload registers hold whenever their stage does not advance.
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_match_ff <= match_in;
         s1_cp_ff    <= req_code_point[INDEX_W-1:0];
      end
      if (adv2) begin
         s2_hit_ff   <= s1_match_ff.hit;
         s2_index_ff <= s2_index_in;
      end
      if (adv3) begin
         s3_hit_ff   <= s2_hit_ff;
         s3_quot_ff  <= s3_quot_in;
         s3_digit_ff <= s3_rem_full[DIGIT_W-1:0];
      end
      if (adv4) begin
         s4_hit_ff   <= s3_hit_ff;
         s4_quot_ff  <= s4_quot_in;
         s4_rem_ff   <= s4_rem_full[REM126_W-1:0];
         s4_digit_ff <= s3_digit_ff;
      end
      if (adv5) begin
         s5_hit_ff <= s4_hit_ff;
         if (s4_hit_ff) begin
            s5_first_ff  <= LEAD_BASE + {{(8-QUOT3_W){1'b0}}, s5_quot_in};
            s5_second_ff <= DIGIT_BASE + {{(8-DIGIT_W){1'b0}}, s5_rem_full[DIGIT_W-1:0]};
            s5_third_ff  <= LEAD_BASE + {{(8-REM126_W){1'b0}}, s4_rem_ff};
            s5_fourth_ff <= DIGIT_BASE + {{(8-DIGIT_W){1'b0}}, s4_digit_ff};
         end else begin
            s5_first_ff  <= '0;
            s5_second_ff <= '0;
            s5_third_ff  <= '0;
            s5_fourth_ff <= '0;
         end
      end
   end

   // Result beat.
   assign rsp_valid       = s5_valid_ff;
   assign rsp_mapped      = s5_hit_ff;
   assign rsp_first_byte  = s5_first_ff;
   assign rsp_second_byte = s5_second_ff;
   assign rsp_third_byte  = s5_third_ff;
   assign rsp_fourth_byte = s5_fourth_ff;

`ifndef ASSERT_OFF
   // The request side backs up only when the result side is stalled.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_stall)
      else $error("request stalled while result side is free");

   // An unmapped result carries all-zero bytes.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_mapped) |-> (rsp_first_byte == 8'h00 && rsp_second_byte == 8'h00
         && rsp_third_byte == 8'h00 && rsp_fourth_byte == 8'h00))
      else $error("unmapped result with nonzero bytes");

   // A mapped result has decimal digits in the second and fourth bytes.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mapped) |-> (rsp_second_byte >= 8'h30 && rsp_second_byte <= 8'h39
         && rsp_fourth_byte >= 8'h30 && rsp_fourth_byte <= 8'h39))
      else $error("digit byte out of range");

   // The lead and third bytes stay within the four-byte code space.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mapped) |-> (rsp_first_byte >= 8'h81 && rsp_first_byte <= 8'hE3
         && rsp_third_byte >= 8'h81 && rsp_third_byte <= 8'hFE))
      else $error("lead or third byte out of range");
`endif

endmodule

// ===== hdl/gbfe_range_match.sv =====
// Range lookup for the GB18030 four-byte encoder.
// Compares one code point against all ranges at once; uses gbfe_pkg.
module gbfe_range_match (
   input  logic [gbfe_pkg::CP_W-1:0] code_point,
   output gbfe_pkg::gbfe_match_type  match
);
   import gbfe_pkg::*;

   logic [NUM_RANGES-1:0] hit_vec;

   // The ranges are disjoint, so an AND-OR picks the one delta that hits.
   always_comb begin
      match.hit   = 1'b0;
      match.delta = '0;
      for (int k = 0; k < NUM_RANGES; k++) begin
         hit_vec[k]  = (code_point >= RANGE_LO[k]) && (code_point <= RANGE_HI[k]);
         match.hit   = match.hit | hit_vec[k];
         match.delta = match.delta | ({INDEX_W{hit_vec[k]}} & range_delta(k));
      end
   end

endmodule
